// ----- rtl/akst_pkg.sv -----
// ----------------------------------------------------------------------------
// akst_pkg
// Types, constants and reserved-word ROM for the assembler symbol table.
// ----------------------------------------------------------------------------
package akst_pkg;

  localparam int TableSize  = 256;
  localparam int MaxChars   = 32;
  localparam int KwTotal    = 90;
  localparam int KwInstrEnd = 45;
  localparam int KwDirEnd   = 55;
  localparam int Slots      = TableSize - KwTotal;
  localparam int Cap        = MaxChars - 1;
  localparam int LenW       = $clog2(Cap + 1);
  localparam int CntW       = $clog2(Slots + 1);
  localparam int AddrW      = $clog2(Slots);
  localparam int KwIdxW     = $clog2(KwTotal);
  localparam int KwChars    = 7;
  localparam int KwLenW     = 3;

  typedef enum logic [1:0] {
    REQ_LOOKUP = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_DUP      = 3'd1,
    ST_RESERVED = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  localparam logic [1:0] CatInstr = 2'd0;
  localparam logic [1:0] CatDir   = 2'd1;
  localparam logic [1:0] CatReg   = 2'd2;
  localparam logic [1:0] CatIdent = 2'd3;

  typedef struct packed {
    logic [Cap*8-1:0] chars;
    logic [LenW-1:0]  len;
    logic [1:0]       cat;
    logic [15:0]      line;
    logic [15:0]      column;
  } sym_entry_t;

  typedef struct packed {
    logic [KwLenW-1:0]    len;
    logic [KwChars*8-1:0] text;
  } kw_rom_t;

  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    fold_lower = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
  endfunction

  // text is right-aligned: the first character sits in the highest used byte
  function automatic kw_rom_t kw_rom(input logic [KwIdxW-1:0] idx);
    kw_rom_t r;
    case (idx)
      7'd0:  r = '{3'd3, 56'("add")};
      7'd1:  r = '{3'd4, 56'("addu")};
      7'd2:  r = '{3'd4, 56'("addi")};
      7'd3:  r = '{3'd5, 56'("addiu")};
      7'd4:  r = '{3'd3, 56'("sub")};
      7'd5:  r = '{3'd4, 56'("subu")};
      7'd6:  r = '{3'd4, 56'("mult")};
      7'd7:  r = '{3'd3, 56'("div")};
      7'd8:  r = '{3'd3, 56'("and")};
      7'd9:  r = '{3'd4, 56'("andi")};
      7'd10: r = '{3'd2, 56'("or")};
      7'd11: r = '{3'd3, 56'("ori")};
      7'd12: r = '{3'd3, 56'("xor")};
      7'd13: r = '{3'd4, 56'("xori")};
      7'd14: r = '{3'd3, 56'("nor")};
      7'd15: r = '{3'd3, 56'("sll")};
      7'd16: r = '{3'd3, 56'("srl")};
      7'd17: r = '{3'd3, 56'("sra")};
      7'd18: r = '{3'd3, 56'("slt")};
      7'd19: r = '{3'd4, 56'("slti")};
      7'd20: r = '{3'd4, 56'("sltu")};
      7'd21: r = '{3'd5, 56'("sltiu")};
      7'd22: r = '{3'd2, 56'("lw")};
      7'd23: r = '{3'd2, 56'("sw")};
      7'd24: r = '{3'd2, 56'("lb")};
      7'd25: r = '{3'd2, 56'("sb")};
      7'd26: r = '{3'd2, 56'("lh")};
      7'd27: r = '{3'd2, 56'("sh")};
      7'd28: r = '{3'd3, 56'("lui")};
      7'd29: r = '{3'd2, 56'("li")};
      7'd30: r = '{3'd2, 56'("la")};
      7'd31: r = '{3'd4, 56'("move")};
      7'd32: r = '{3'd4, 56'("mfhi")};
      7'd33: r = '{3'd4, 56'("mflo")};
      7'd34: r = '{3'd3, 56'("beq")};
      7'd35: r = '{3'd3, 56'("bne")};
      7'd36: r = '{3'd3, 56'("blt")};
      7'd37: r = '{3'd3, 56'("bgt")};
      7'd38: r = '{3'd3, 56'("ble")};
      7'd39: r = '{3'd3, 56'("bge")};
      7'd40: r = '{3'd1, 56'("j")};
      7'd41: r = '{3'd3, 56'("jal")};
      7'd42: r = '{3'd2, 56'("jr")};
      7'd43: r = '{3'd7, 56'("syscall")};
      7'd44: r = '{3'd3, 56'("nop")};
      7'd45: r = '{3'd5, 56'(".data")};
      7'd46: r = '{3'd5, 56'(".text")};
      7'd47: r = '{3'd6, 56'(".globl")};
      7'd48: r = '{3'd6, 56'(".align")};
      7'd49: r = '{3'd6, 56'(".space")};
      7'd50: r = '{3'd5, 56'(".byte")};
      7'd51: r = '{3'd5, 56'(".half")};
      7'd52: r = '{3'd5, 56'(".word")};
      7'd53: r = '{3'd6, 56'(".ascii")};
      7'd54: r = '{3'd7, 56'(".asciiz")};
      7'd55: r = '{3'd5, 56'("$zero")};
      7'd56: r = '{3'd3, 56'("$at")};
      7'd57: r = '{3'd3, 56'("$v0")};
      7'd58: r = '{3'd3, 56'("$v1")};
      7'd59: r = '{3'd3, 56'("$a0")};
      7'd60: r = '{3'd3, 56'("$a1")};
      7'd61: r = '{3'd3, 56'("$a2")};
      7'd62: r = '{3'd3, 56'("$a3")};
      7'd63: r = '{3'd3, 56'("$t0")};
      7'd64: r = '{3'd3, 56'("$t1")};
      7'd65: r = '{3'd3, 56'("$t2")};
      7'd66: r = '{3'd3, 56'("$t3")};
      7'd67: r = '{3'd3, 56'("$t4")};
      7'd68: r = '{3'd3, 56'("$t5")};
      7'd69: r = '{3'd3, 56'("$t6")};
      7'd70: r = '{3'd3, 56'("$t7")};
      7'd71: r = '{3'd3, 56'("$t8")};
      7'd72: r = '{3'd3, 56'("$t9")};
      7'd73: r = '{3'd3, 56'("$s0")};
      7'd74: r = '{3'd3, 56'("$s1")};
      7'd75: r = '{3'd3, 56'("$s2")};
      7'd76: r = '{3'd3, 56'("$s3")};
      7'd77: r = '{3'd3, 56'("$s4")};
      7'd78: r = '{3'd3, 56'("$s5")};
      7'd79: r = '{3'd3, 56'("$s6")};
      7'd80: r = '{3'd3, 56'("$s7")};
      7'd81: r = '{3'd3, 56'("$s8")};
      7'd82: r = '{3'd3, 56'("$k0")};
      7'd83: r = '{3'd3, 56'("$k1")};
      7'd84: r = '{3'd3, 56'("$gp")};
      7'd85: r = '{3'd3, 56'("$sp")};
      7'd86: r = '{3'd3, 56'("$fp")};
      7'd87: r = '{3'd3, 56'("$ra")};
      7'd88: r = '{3'd3, 56'("$hi")};
      7'd89: r = '{3'd3, 56'("$lo")};
      default: r = '{3'd0, 56'd0};
    endcase
    kw_rom = r;
  endfunction

  function automatic logic [1:0] kw_cat(input logic [KwIdxW-1:0] idx);
    if (idx < KwIdxW'(KwInstrEnd)) kw_cat = CatInstr;
    else if (idx < KwIdxW'(KwDirEnd)) kw_cat = CatDir;
    else kw_cat = CatReg;
  endfunction

endpackage

// ----- rtl/akst_if.sv -----
// ----------------------------------------------------------------------------
// akst_req_if / akst_res_if
// Valid/ready channels for lexeme characters and lookup/insert results.
// ----------------------------------------------------------------------------
interface akst_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  char_code;
  logic        last_char;
  logic [1:0]  insert_category;
  logic [15:0] source_line;
  logic [15:0] source_column;

  modport source (output valid, req_type, char_code, last_char, insert_category,
                  source_line, source_column, input ready);
  modport sink (input valid, req_type, char_code, last_char, insert_category,
                source_line, source_column, output ready);
endinterface

interface akst_res_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [1:0] found_category;
  logic [2:0] insert_status;

  modport source (output valid, hit, found_category, insert_status, input ready);
  modport sink (input valid, hit, found_category, insert_status, output ready);
endinterface

// ----- rtl/assembler_keyword_symbol_table_unit.sv -----
// ----------------------------------------------------------------------------
// assembler_keyword_symbol_table_unit
// Symbol table with reserved keyword ROM, fed one lexeme character at a time.
// ----------------------------------------------------------------------------
// a closing character of a lookup or insert request starts a scan that tests
// one reserved word per cycle, then reads and compares each stored symbol in
// turn (one memory read, one compare), and the result is then registered
// reset clears the sequencer, lexeme length and symbol count; the symbol memory
// is not cleared, no clearing pass is needed
module assembler_keyword_symbol_table_unit (
  input logic         clk_i,
  input logic         rst_ni,
  akst_req_if.sink    req_i,
  akst_res_if.source  res_o
);
  import akst_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_KW   = 4'b0010,
    S_SRD  = 4'b0100,
    S_SCMP = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [Cap*8-1:0]    lex_q;
  logic [LenW-1:0]     len_q;
  logic                ovl_q;
  logic [KwIdxW-1:0]   k_q;
  logic [CntW-1:0]     s_q;
  logic [CntW-1:0]     count_q;
  req_e                req_q;
  logic [1:0]          cat_q;
  logic [15:0]         line_q;
  logic [15:0]         col_q;
  logic                out_valid_q;
  logic                hit_q;
  logic [1:0]          fcat_q;
  logic [2:0]          status_q;

  logic                in_fire, out_fire;
  logic [Cap*8-1:0]    lower, key, mask;
  logic [KwChars*8-1:0] kw_head, kw_key;
  logic [KwLenW-1:0]   kw_shamt;
  kw_rom_t             rom;
  logic                kw_match, sym_match;
  sym_entry_t          wdata, rdata;
  logic                we;
  logic                fin, fin_hit;
  logic [1:0]          fin_cat;
  status_e             fin_status;
  logic                k_inc, s_inc, s_clr, cnt_clr;

  assign in_fire  = req_i.valid && req_i.ready;
  assign out_fire = res_o.valid && res_o.ready;
  assign req_i.ready = (state_q == S_IDLE) && !out_valid_q;

  always_comb begin
    for (int i = 0; i < Cap; i++) begin
      lower[8*i +: 8] = fold_lower(lex_q[8*i +: 8]);
      mask[8*i +: 8]  = (LenW'(i) < len_q) ? 8'hFF : 8'h00;
    end
    for (int i = 0; i < KwChars; i++) begin
      kw_head[8*(KwChars-1-i) +: 8] = lower[8*i +: 8];
    end
  end

  // right-align the first characters the way the ROM stores them
  assign kw_shamt = KwLenW'(KwChars) - len_q[KwLenW-1:0];
  assign kw_key   = kw_head >> {kw_shamt, 3'b000};
  assign rom      = kw_rom(k_q);
  assign kw_match = (len_q == LenW'(rom.len)) && (kw_key == rom.text);

  assign key = (req_q == REQ_INSERT && cat_q != CatIdent) ? lower : lex_q;
  assign sym_match = (rdata.len == len_q) && (((rdata.chars ^ key) & mask) == '0);

  assign wdata = '{chars: key, len: len_q, cat: cat_q, line: line_q, column: col_q};

  akst_sym_store u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (wdata),
    .raddr_i (s_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d    = state_q;
    fin        = 1'b0;
    fin_hit    = 1'b0;
    fin_cat    = CatInstr;
    fin_status = ST_INSERTED;
    we         = 1'b0;
    k_inc      = 1'b0;
    s_inc      = 1'b0;
    s_clr      = 1'b0;
    cnt_clr    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire && req_i.last_char) state_d = S_KW;
      end
      S_KW: begin
        if (req_q == REQ_CLEAR || req_q == REQ_NONE) begin
          fin     = 1'b1;
          cnt_clr = (req_q == REQ_CLEAR);
        end else if (req_q == REQ_INSERT && len_q == '0) begin
          fin        = 1'b1;
          fin_status = ST_EMPTY;
        end else if (kw_match) begin
          fin = 1'b1;
          if (req_q == REQ_LOOKUP) begin
            fin_hit = 1'b1;
            fin_cat = kw_cat(k_q);
          end else begin
            fin_status = ST_RESERVED;
          end
        end else if (k_q == KwIdxW'(KwTotal - 1)) begin
          if (req_q == REQ_LOOKUP && ovl_q) begin
            fin = 1'b1;
          end else begin
            s_clr   = 1'b1;
            state_d = S_SRD;
          end
        end else begin
          k_inc = 1'b1;
        end
      end
      S_SRD: begin
        if (s_q == count_q) begin
          fin = 1'b1;
          if (req_q == REQ_INSERT) begin
            if (count_q >= CntW'(Slots)) begin
              fin_status = ST_FULL;
            end else begin
              we = 1'b1;
            end
          end
        end else begin
          state_d = S_SCMP;
        end
      end
      S_SCMP: begin
        if (sym_match) begin
          fin = 1'b1;
          if (req_q == REQ_LOOKUP) begin
            fin_hit = 1'b1;
            fin_cat = rdata.cat;
          end else begin
            fin_status = ST_DUP;
          end
        end else begin
          s_inc   = 1'b1;
          state_d = S_SRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (fin) state_d = S_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      ovl_q       <= 1'b0;
      k_q         <= '0;
      s_q         <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire && req_i.char_code != 8'd0) begin
        if (len_q < LenW'(Cap)) len_q <= len_q + 1'b1;
        else ovl_q <= 1'b1;
      end
      if (in_fire && req_i.last_char) k_q <= '0;
      else if (k_inc) k_q <= k_q + 1'b1;
      if (s_clr) s_q <= '0;
      else if (s_inc) s_q <= s_q + 1'b1;
      if (cnt_clr) count_q <= '0;
      else if (we) count_q <= count_q + 1'b1;
      if (fin) begin
        len_q       <= '0;
        ovl_q       <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      if (req_i.char_code != 8'd0 && len_q < LenW'(Cap)) begin
        lex_q[8*len_q +: 8] <= req_i.char_code;
      end
      if (req_i.last_char) begin
        req_q  <= req_e'(req_i.req_type);
        cat_q  <= req_i.insert_category;
        line_q <= req_i.source_line;
        col_q  <= req_i.source_column;
      end
    end
    if (fin) begin
      hit_q    <= fin_hit;
      fcat_q   <= fin_cat;
      status_q <= fin_status;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.hit            = hit_q;
  assign res_o.found_category = fcat_q;
  assign res_o.insert_status  = status_q;

endmodule

// ----- rtl/akst_sym_store.sv -----
// ----------------------------------------------------------------------------
// akst_sym_store
// Inserted-symbol memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module akst_sym_store (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [akst_pkg::AddrW-1:0] waddr_i,
  input  akst_pkg::sym_entry_t      wdata_i,
  input  logic [akst_pkg::AddrW-1:0] raddr_i,
  output akst_pkg::sym_entry_t      rdata_o
);
  import akst_pkg::*;

  sym_entry_t mem_q [Slots];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
